// ===== rtl/seg_pkg.sv =====
package seg_pkg;

    // accumulator holds up to seven leftover bits plus one 17-bit codeword
    localparam int ACC_W   = 24;
    localparam int MAP_W   = 9;
    localparam int LEN_W   = 5;
    localparam int PEND_W  = 5;
    localparam int BYTE_W  = 8;
    localparam int TOTAL_W = 32;
    localparam int QDEPTH  = 2;

    typedef struct packed {
        logic signed [7:0] sample_value;
        logic              end_of_block;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]  packed_byte;
        logic               block_done;
        logic [TOTAL_W-1:0] bit_total;
    } t_out;

    // classified request handed from front to back
    typedef struct packed {
        logic [MAP_W-1:0] mapped;
        logic [LEN_W-1:0] code_len;
        logic             last;
    } t_code;

endpackage

// ===== rtl/seg_fifo.sv =====
module seg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue fill beyond depth");

endmodule

// ===== rtl/seg_front.sv =====
module seg_front (
    input  seg_pkg::t_in   i_sample,
    input  logic           i_push,
    input  logic           i_q_full,
    output logic           o_full,
    output logic           o_q_push,
    output seg_pkg::t_code o_code
);
    import seg_pkg::*;

    logic [MAP_W-1:0] mag;
    logic [MAP_W-1:0] mapped;
    logic [LEN_W-1:0] bit_len;

    always_comb begin
        // magnitude of a negative sample, -128 gives 128
        mag = MAP_W'(0) - {i_sample.sample_value[7], i_sample.sample_value};
        if (i_sample.sample_value[7]) begin
            mapped = {mag[7:0], 1'b0};
        end else begin
            mapped = {i_sample.sample_value[7:0], 1'b1};
        end
        bit_len = '0;
        for (int i = 0; i < MAP_W; i++) begin
            if (mapped[i]) begin
                bit_len = LEN_W'(i + 1);
            end
        end
    end

    assign o_code.mapped   = mapped;
    assign o_code.code_len = {bit_len[LEN_W-2:0], 1'b0} - 1'b1;
    assign o_code.last     = i_sample.end_of_block;
    assign o_q_push        = i_push;
    assign o_full          = i_q_full;

endmodule

// ===== rtl/seg_pack.sv =====
module seg_pack #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  seg_pkg::t_code i_code,
    input  logic           i_code_valid,
    output logic           o_code_pop,
    output seg_pkg::t_out  o_byte,
    output logic           o_push,
    input  logic           i_full
);
    import seg_pkg::*;

    logic [ACC_W-1:0]       r_acc, n_acc;
    logic [PEND_W-1:0]      r_pend, n_pend;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_work, n_work;
    logic                   r_last, n_last;

    logic [ACC_W-1:0]       acc_e;
    logic [PEND_W-1:0]      pend_e;
    logic                   fin;
    logic [ACC_W-1:0]       base_acc;
    logic [PEND_W-1:0]      base_pend;
    logic [COUNT_WIDTH-1:0] base_count;
    logic [PEND_W-1:0]      sh;
    logic [ACC_W-1:0]       acc_l;
    logic [PEND_W-1:0]      pend_l;
    logic [COUNT_WIDTH:0]   sum_l;
    logic [COUNT_WIDTH-1:0] count_l;
    logic [TOTAL_W-1:0]     total_sat;

    // emit the top byte of the accumulator
    assign o_push = r_work && !i_full;
    assign acc_e  = {r_acc[ACC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    assign pend_e = (r_pend >= PEND_W'(BYTE_W)) ? r_pend - PEND_W'(BYTE_W) : '0;
    assign fin    = o_push && !(pend_e >= PEND_W'(BYTE_W) || (r_last && pend_e != '0));

    generate
        if (COUNT_WIDTH > TOTAL_W) begin : g_sat
            assign total_sat = (|r_count[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                                                 : r_count[TOTAL_W-1:0];
        end else begin : g_ext
            assign total_sat = TOTAL_W'(r_count);
        end
    endgenerate

    assign o_byte.packed_byte = r_acc[ACC_W-1:ACC_W-BYTE_W];
    assign o_byte.block_done  = r_last && fin;
    assign o_byte.bit_total   = (r_last && fin) ? total_sat : '0;

    // next request may be loaded in the cycle the current one finishes
    assign o_code_pop = i_code_valid && (!r_work || fin);

    always_comb begin
        if (o_push && fin && r_last) begin
            base_acc   = '0;
            base_pend  = '0;
            base_count = '0;
        end else if (o_push) begin
            base_acc   = acc_e;
            base_pend  = pend_e;
            base_count = r_count;
        end else begin
            base_acc   = r_acc;
            base_pend  = r_pend;
            base_count = r_count;
        end

        // place the codeword right after the leftover bits
        sh      = PEND_W'(ACC_W) - base_pend - i_code.code_len;
        acc_l   = base_acc | (ACC_W'(i_code.mapped) << sh);
        pend_l  = base_pend + i_code.code_len;
        sum_l   = {1'b0, base_count} + (COUNT_WIDTH + 1)'(i_code.code_len);
        count_l = sum_l[COUNT_WIDTH] ? '1 : sum_l[COUNT_WIDTH-1:0];
    end

    always_comb begin
        n_acc   = r_acc;
        n_pend  = r_pend;
        n_count = r_count;
        n_work  = r_work;
        n_last  = r_last;
        if (o_code_pop) begin
            n_acc   = acc_l;
            n_pend  = pend_l;
            n_count = count_l;
            n_work  = (pend_l >= PEND_W'(BYTE_W)) || i_code.last;
            n_last  = i_code.last;
        end else if (o_push) begin
            n_acc   = base_acc;
            n_pend  = base_pend;
            n_count = base_count;
            n_work  = !fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_pend  <= '0;
            r_count <= '0;
            r_work  <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_work  <= n_work;
            r_last  <= n_last;
        end
    end

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(ACC_W))
        else $error("pending bit count beyond accumulator");

    a_idle_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_work |-> r_pend < PEND_W'(BYTE_W))
        else $error("whole byte left pending while idle");

    a_work_has_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_work |-> r_pend != '0)
        else $error("byte emission with no pending bits");

    a_block_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_byte.block_done && !o_code_pop)
            |=> (r_pend == '0 && r_count == '0 && !r_work))
        else $error("block state not cleared after final byte");

endmodule

// ===== rtl/signed_exp_golomb_encoder.sv =====
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | push in, full out    | i_sample : sample_value, end_of_block
// result   | empty out, pop in    | o_result : packed_byte, block_done, bit_total
//
// the packer emits one byte per cycle while the result queue is not full, and a
// value stays there until its completed bytes are out; a block end adds its padded byte
// a value that completes no byte is absorbed without emitting one
// input and result sides each have a two-entry queue and stall on their own
// reset is synchronous, active low, and clears the queues and the packer

module signed_exp_golomb_encoder #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  seg_pkg::t_in  i_sample,
    output logic          empty,
    input  logic          pop,
    output seg_pkg::t_out o_result
);
    import seg_pkg::*;

    t_code code_in;
    t_code code_out;
    logic  q_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    t_out  byte_out;
    logic  ob_push;
    logic  ob_full;

    seg_front u_front (
        .i_sample (i_sample),
        .i_push   (push),
        .i_q_full (q_full),
        .o_full   (full),
        .o_q_push (q_push),
        .o_code   (code_in)
    );

    seg_fifo #(
        .WIDTH ($bits(t_code)),
        .DEPTH (QDEPTH)
    ) u_code_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (code_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (code_out),
        .o_empty (q_empty)
    );

    seg_pack #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pack (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_code       (code_out),
        .i_code_valid (!q_empty),
        .o_code_pop   (q_pop),
        .o_byte       (byte_out),
        .o_push       (ob_push),
        .i_full       (ob_full)
    );

    seg_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (QDEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ob_push),
        .i_data  (byte_out),
        .o_full  (ob_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
